/* src/rcff_pkg.sv */
// ---------------------------------------------------------------------------
// rcff_pkg
// Shared types, constants and helper functions for the radix conversion
// block: payload structs, microcode word layout and character tables.
// ---------------------------------------------------------------------------
package rcff_pkg;

   localparam int FIELD_WIDTH = 7;

   localparam int ACC_W      = 28;
   localparam int BASE_W     = 5;
   localparam int DIG_W      = 4;
   localparam int CHAR_W     = 8;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = ACC_W / DIV_BITS;
   localparam int DSTEP_W    = $clog2(DIV_STEPS);
   localparam int CNT_W      = $clog2(FIELD_WIDTH + 1);
   localparam int IDX_W      = (FIELD_WIDTH > 1) ? $clog2(FIELD_WIDTH) : 1;
   localparam int LEFT_W     = (CNT_W > 3) ? CNT_W : 3;
   localparam int ERR_LEN    = 5;
   localparam int ERR_PAD    = (FIELD_WIDTH > ERR_LEN) ? FIELD_WIDTH - ERR_LEN : 0;
   localparam int STEP_W     = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACC_W-1:0]  ACC_MAX       = {ACC_W{1'b1}};
   localparam logic [BASE_W-1:0] BASE_RESET    = 5'd10;
   localparam logic [BASE_W-1:0] BASE_MIN      = 5'd2;
   localparam logic [BASE_W-1:0] BASE_MAX      = 5'd16;
   localparam logic [BASE_W-1:0] DIGIT_INVALID = 5'd16;
   localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F  = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_E  = 8'h45;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_R  = 8'h52;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_O  = 8'h4F;

   // register index, taken from paddr bit 2
   localparam logic REG_SOURCE_BASE = 1'b0;
   localparam logic REG_TARGET_BASE = 1'b1;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              out_last;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCUM,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_DIV_STORE,
      OP_SET_ERR_NOPAD,
      OP_SET_ERR_PAD,
      OP_SET_DIGITS,
      OP_EMIT,
      OP_CLEAR
   } op_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NOT_LAST,
      COND_BAD,
      COND_BIG,
      COND_DIV_MORE,
      COND_VZERO,
      COND_NOT_FULL,
      COND_EMIT_MORE
   } cond_type;

   typedef struct packed {
      logic              wait_in;
      logic              emit;
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic in_accept;
      logic in_last;
      logic bad;
      logic big;
      logic div_more;
      logic vzero;
      logic not_full;
      logic emit_more;
      logic out_free;
   } stat_type;

   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      if (b < BASE_MIN) begin
         r = BASE_MIN;
      end else if (b > BASE_MAX) begin
         r = BASE_MAX;
      end else begin
         r = b;
      end
      return r;
   endfunction

   function automatic logic [BASE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] t;
      logic [BASE_W-1:0] r;
      r = DIGIT_INVALID;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         t = c - CHAR_ZERO;
         r = t[BASE_W-1:0];
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         t = c - CHAR_UPPER_A + 8'd10;
         r = t[BASE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
      logic [CHAR_W-1:0] r;
      if (d < 4'd10) begin
         r = CHAR_ZERO + CHAR_W'(d);
      end else begin
         r = CHAR_UPPER_A + CHAR_W'(d) - 8'd10;
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] err_char(input logic [2:0] idx);
      logic [CHAR_W-1:0] r;
      case (idx)
         3'd0: r = CHAR_UPPER_E;
         3'd1: r = CHAR_UPPER_R;
         3'd2: r = CHAR_UPPER_R;
         3'd3: r = CHAR_UPPER_O;
         3'd4: r = CHAR_UPPER_R;
         default: r = CHAR_SPACE;
      endcase
      return r;
   endfunction

endpackage

/* src/rcff_sequencer.sv */
// ---------------------------------------------------------------------------
// rcff_sequencer
// Microcode store and step counter: one control word per step, with a
// conditional jump and stalls on the input and output handshakes.
// ---------------------------------------------------------------------------
module rcff_sequencer
   import rcff_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat_i,
   output ctl_type  ctl_o
);

   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CHECK_BAD = 4'd1;
   localparam logic [STEP_W-1:0] STEP_CHECK_BIG = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DIV_LOAD  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DIV       = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DIV_STORE = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DIV_TEST  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_OVERFLOW  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_ERR_NOPAD = 4'd8;
   localparam logic [STEP_W-1:0] STEP_ERR_PAD   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_DIGITS    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd11;
   localparam logic [STEP_W-1:0] STEP_CLEAR     = 4'd12;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ctl_type           word;
   logic              hold;
   logic              taken;

   // control store
   always_comb begin
      case (step_ff)
         STEP_IDLE: word = '{wait_in: 1'b1, emit: 1'b0, op: OP_ACCUM,
                             cond: COND_NOT_LAST, target: STEP_IDLE};
         STEP_CHECK_BAD: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_NONE,
                                  cond: COND_BAD, target: STEP_ERR_NOPAD};
         STEP_CHECK_BIG: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_NONE,
                                  cond: COND_BIG, target: STEP_ERR_PAD};
         STEP_DIV_LOAD: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_DIV_LOAD,
                                 cond: COND_NEVER, target: STEP_IDLE};
         STEP_DIV: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_DIV_STEP,
                            cond: COND_DIV_MORE, target: STEP_DIV};
         STEP_DIV_STORE: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_DIV_STORE,
                                  cond: COND_VZERO, target: STEP_DIGITS};
         STEP_DIV_TEST: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_NONE,
                                 cond: COND_NOT_FULL, target: STEP_DIV};
         STEP_OVERFLOW: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_NONE,
                                 cond: COND_ALWAYS, target: STEP_ERR_PAD};
         STEP_ERR_NOPAD: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_SET_ERR_NOPAD,
                                  cond: COND_ALWAYS, target: STEP_EMIT};
         STEP_ERR_PAD: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_SET_ERR_PAD,
                                cond: COND_ALWAYS, target: STEP_EMIT};
         STEP_DIGITS: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_SET_DIGITS,
                               cond: COND_NEVER, target: STEP_IDLE};
         STEP_EMIT: word = '{wait_in: 1'b0, emit: 1'b1, op: OP_EMIT,
                             cond: COND_EMIT_MORE, target: STEP_EMIT};
         STEP_CLEAR: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_CLEAR,
                              cond: COND_ALWAYS, target: STEP_IDLE};
         default: word = '{wait_in: 1'b0, emit: 1'b0, op: OP_NONE,
                           cond: COND_ALWAYS, target: STEP_IDLE};
      endcase
   end

   always_comb begin
      case (word.cond)
         COND_NEVER:     taken = 1'b0;
         COND_ALWAYS:    taken = 1'b1;
         COND_NOT_LAST:  taken = !stat_i.in_last;
         COND_BAD:       taken = stat_i.bad;
         COND_BIG:       taken = stat_i.big;
         COND_DIV_MORE:  taken = stat_i.div_more;
         COND_VZERO:     taken = stat_i.vzero;
         COND_NOT_FULL:  taken = stat_i.not_full;
         COND_EMIT_MORE: taken = stat_i.emit_more;
         default:        taken = 1'b0;
      endcase

      hold = (word.wait_in && !stat_i.in_accept) || (word.emit && !stat_i.out_free);

      if (hold) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + 1'b1;
      end

      // a stalled step does nothing to the datapath
      ctl_o = word;
      if (hold) begin
         ctl_o.op = OP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* src/rcff_datapath.sv */
// ---------------------------------------------------------------------------
// rcff_datapath
// Horner accumulator, shift-subtract divider, digit store and the output
// register, each driven by the operation code of the current step.
// ---------------------------------------------------------------------------
module rcff_datapath
   import rcff_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  op_type            op_i,
   input  logic [BASE_W-1:0] src_base_i,
   input  logic [BASE_W-1:0] tgt_base_i,
   input  req_type           req_data_i,
   input  logic              in_accept_i,
   output stat_type          stat_o,
   output logic              rsp_valid_o,
   input  logic              rsp_ready_i,
   output rsp_type           rsp_data_o
);

   logic [ACC_W-1:0]   acc_ff,   acc_in;
   logic               big_ff,   big_in;
   logic               bad_ff,   bad_in;
   logic [ACC_W-1:0]   quo_ff,   quo_in;
   logic [BASE_W-1:0]  rem_ff,   rem_in;
   logic [DSTEP_W-1:0] dstep_ff, dstep_in;
   logic [CNT_W-1:0]   cnt_ff,   cnt_in;
   logic [CNT_W-1:0]   pad_ff,   pad_in;
   logic [LEFT_W-1:0]  left_ff,  left_in;
   logic               err_ff,   err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff,  rsp_data_in;
   logic [DIG_W-1:0]   store_ff [FIELD_WIDTH];
   logic               store_we;

   logic [BASE_W-1:0]        sb;
   logic [BASE_W-1:0]        tb;
   logic [BASE_W-1:0]        dval;
   logic [ACC_W+BASE_W-1:0]  next_val;
   logic [ACC_W-1:0]         q;
   logic [BASE_W-1:0]        r;
   logic [LEFT_W-1:0]        left_m1;
   logic [2:0]               eidx;
   logic [CHAR_W-1:0]        emit_char;

   always_comb begin
      sb   = clamp_base(src_base_i);
      tb   = clamp_base(tgt_base_i);
      dval = digit_value(req_data_i.char_code);
      next_val = ({{BASE_W{1'b0}}, acc_ff} * {{ACC_W{1'b0}}, sb})
               + {{ACC_W{1'b0}}, dval};

      // radix-16 restoring division: four quotient bits per cycle
      q = quo_ff;
      r = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         r = {r[DIG_W-1:0], q[ACC_W-1]};
         q = {q[ACC_W-2:0], 1'b0};
         if (r >= tb) begin
            r    = r - tb;
            q[0] = 1'b1;
         end
      end

      left_m1 = left_ff - 1'b1;
      eidx    = 3'(ERR_LEN) - left_ff[2:0];
      if (pad_ff != '0) begin
         emit_char = CHAR_SPACE;
      end else if (err_ff) begin
         emit_char = err_char(eidx);
      end else begin
         emit_char = digit_char(store_ff[left_m1[IDX_W-1:0]]);
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      big_in       = big_ff;
      bad_in       = bad_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dstep_in     = dstep_ff;
      cnt_in       = cnt_ff;
      pad_in       = pad_ff;
      left_in      = left_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready_i;
      rsp_data_in  = rsp_data_ff;
      store_we     = 1'b0;

      case (op_i)
         OP_ACCUM: begin
            if (dval >= sb) begin
               bad_in = 1'b1;
            end else if (!big_ff) begin
               if (next_val[ACC_W+BASE_W-1:ACC_W] != '0) begin
                  big_in = 1'b1;
                  acc_in = ACC_MAX;
               end else begin
                  acc_in = next_val[ACC_W-1:0];
               end
            end
         end
         OP_DIV_LOAD: begin
            quo_in   = acc_ff;
            rem_in   = '0;
            dstep_in = '0;
            cnt_in   = '0;
         end
         OP_DIV_STEP: begin
            quo_in   = q;
            rem_in   = r;
            dstep_in = dstep_ff + 1'b1;
         end
         OP_DIV_STORE: begin
            store_we = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            rem_in   = '0;
            dstep_in = '0;
         end
         OP_SET_ERR_NOPAD: begin
            pad_in  = '0;
            left_in = LEFT_W'(ERR_LEN);
            err_in  = 1'b1;
         end
         OP_SET_ERR_PAD: begin
            pad_in  = CNT_W'(ERR_PAD);
            left_in = LEFT_W'(ERR_LEN);
            err_in  = 1'b1;
         end
         OP_SET_DIGITS: begin
            pad_in  = CNT_W'(FIELD_WIDTH) - cnt_ff;
            left_in = LEFT_W'(cnt_ff);
            err_in  = 1'b0;
         end
         OP_EMIT: begin
            rsp_valid_in         = 1'b1;
            rsp_data_in.out_char = emit_char;
            rsp_data_in.out_last = (pad_ff == '0) && (left_ff == LEFT_W'(1));
            if (pad_ff != '0) begin
               pad_in = pad_ff - 1'b1;
            end else begin
               left_in = left_m1;
            end
         end
         OP_CLEAR: begin
            acc_in = '0;
            big_in = 1'b0;
            bad_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         big_ff       <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         big_ff       <= big_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dstep_ff    <= dstep_in;
      cnt_ff      <= cnt_in;
      pad_ff      <= pad_in;
      left_ff     <= left_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      if (store_we) begin
         store_ff[cnt_ff[IDX_W-1:0]] <= rem_ff[DIG_W-1:0];
      end
   end

   always_comb begin
      stat_o.in_accept = in_accept_i;
      stat_o.in_last   = req_data_i.last_char;
      stat_o.bad       = bad_ff;
      stat_o.big       = big_ff;
      stat_o.div_more  = dstep_ff != DSTEP_W'(DIV_STEPS - 1);
      stat_o.vzero     = quo_ff == '0;
      stat_o.not_full  = cnt_ff < CNT_W'(FIELD_WIDTH);
      stat_o.emit_more = !((pad_ff == '0) && (left_ff == LEFT_W'(1)));
      stat_o.out_free  = !rsp_valid_ff || rsp_ready_i;
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_data_o  = rsp_data_ff;

endmodule

/* src/radix_conversion_fixed_field.sv */
// ---------------------------------------------------------------------------
// radix_conversion_fixed_field
// Reads a number as ASCII digits in one base and writes it as a
// right-justified seven-character field in another base.
// ---------------------------------------------------------------------------
//   channel  dir  handshake        payload
//   req      in   valid / ready    req_type: char_code, last_char
//   rsp      out  valid / ready    rsp_type: out_char, out_last
//   csr      in   apb, pready = 1  source_base @ 0x0, target_base @ 0x4
//
// a digit that is not last is accepted and the block is ready again next cycle
// a last digit runs two checks and the divider load, then for each output digit
//   the divide steps, a store and a test (no test after the last), then a step to
//   set up the field or the error, the emit step while rsp is ready and a clear
// a stalled rsp holds the sequencer on the emit step; req is then not ready
// reset is synchronous and returns both bases to 10 and clears the number
module radix_conversion_fixed_field
   import rcff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [BASE_W-1:0] src_base_ff, src_base_in;
   logic [BASE_W-1:0] tgt_base_ff, tgt_base_in;
   logic              csr_write;
   logic              in_accept;
   ctl_type           ctl;
   stat_type          stat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      src_base_in = src_base_ff;
      tgt_base_in = tgt_base_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_TARGET_BASE) begin
            tgt_base_in = csr_pwdata[BASE_W-1:0];
         end else begin
            src_base_in = csr_pwdata[BASE_W-1:0];
         end
      end
      if (csr_paddr[2] == REG_SOURCE_BASE) begin
         csr_prdata = {{(CSR_DATA_W-BASE_W){1'b0}}, src_base_ff};
      end else begin
         csr_prdata = {{(CSR_DATA_W-BASE_W){1'b0}}, tgt_base_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_base_ff <= BASE_RESET;
         tgt_base_ff <= BASE_RESET;
      end else begin
         src_base_ff <= src_base_in;
         tgt_base_ff <= tgt_base_in;
      end
   end

   assign req_ready = ctl.wait_in;
   assign in_accept = req_valid && ctl.wait_in;

   rcff_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .stat_i (stat),
      .ctl_o  (ctl)
   );

   rcff_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .op_i        (ctl.op),
      .src_base_i  (src_base_ff),
      .tgt_base_i  (tgt_base_ff),
      .req_data_i  (req_data),
      .in_accept_i (in_accept),
      .stat_o      (stat),
      .rsp_valid_o (rsp_valid),
      .rsp_ready_i (rsp_ready),
      .rsp_data_o  (rsp_data)
   );

endmodule

/* src/rcff_checker.sv */
// ---------------------------------------------------------------------------
// rcff_checker
// Port-level checks on the radix conversion block, bound to the top level.
// ---------------------------------------------------------------------------
module rcff_checker
   import rcff_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result transaction holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   // a closing digit starts the conversion, so no digit is taken next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_char |=> !req_ready)
      else $error("req taken during conversion");

   // a digit that does not close the number leaves the block ready
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.last_char |=> req_ready)
      else $error("req not ready after inner digit");

   // the closing character of a field is never padding
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_last |-> rsp_data.out_char != CHAR_SPACE)
      else $error("field ends in a space");

endmodule

bind radix_conversion_fixed_field rcff_checker u_rcff_checker (.*);

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the radix conversion block. Digits are streamed
// in over req, the expected seven-character fields are predicted in the
// bench and every rsp transaction is checked in order. Bases are changed
// over the csr port between phases, including out-of-range values.
// ---------------------------------------------------------------------------
module tb;
   import rcff_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 90;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RAND_ITEMS    = 140;
   localparam logic [39:0] ERR_WORD = "ERROR";

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // bench copy of the block state
   logic [BASE_W-1:0] src_base_q = BASE_RESET;
   logic [BASE_W-1:0] tgt_base_q = BASE_RESET;
   logic [ACC_W-1:0]  acc_q = '0;
   bit                big_q = 1'b0;
   bit                bad_q = 1'b0;
   rsp_type           field_q[$];

   int idle_in = 0;
   int idle_out = 0;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int n_errors = 0;
   int n_items = 0;
   int n_out = 0;
   int n_fields = 0;

   radix_conversion_fixed_field uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
      if (b < BASE_MIN) return BASE_MIN;
      if (b > BASE_MAX) return BASE_MAX;
      return b;
   endfunction

   // non-digits count as 16 so they fail in every base
   function automatic logic [BASE_W-1:0] char_digit(input logic [CHAR_W-1:0] c);
      if (c >= "0" && c <= "9") return BASE_W'(c - "0");
      if (c >= "A" && c <= "F") return BASE_W'(c - "A" + 10);
      return DIGIT_INVALID;
   endfunction

   function automatic logic [CHAR_W-1:0] glyph(input logic [DIG_W-1:0] d);
      return (d < 10) ? CHAR_W'("0" + d) : CHAR_W'("A" + d - 10);
   endfunction

   function automatic void flag_error(input string msg);
      n_errors++;
      if (n_errors <= 10) $display("%s", msg);
   endfunction

   function automatic void push_char(input logic [CHAR_W-1:0] c, input bit l);
      rsp_type r;
      r.out_char = c;
      r.out_last = l;
      field_q.push_back(r);
   endfunction

   function automatic void push_error(input bit padded);
      if (padded) begin
         for (int i = 5; i < FIELD_WIDTH; i++) push_char(CHAR_SPACE, 1'b0);
      end
      for (int i = 0; i < 5; i++) push_char(ERR_WORD[8*(4-i) +: 8], i == 4);
   endfunction

   // horner step per digit; the last digit converts and queues the field
   function automatic void fold_char(input req_type item);
      logic [BASE_W-1:0] sb;
      logic [BASE_W-1:0] to_base;
      logic [BASE_W-1:0] d;
      logic [32:0]       nxt;
      logic [ACC_W-1:0]  v;
      logic [DIG_W-1:0]  digs [FIELD_WIDTH];
      int                cnt;
      bit                ovf;
      sb = eff_base(src_base_q);
      d = char_digit(item.char_code);
      if (d >= sb) begin
         bad_q = 1'b1;
      end else if (!big_q) begin
         nxt = 33'(acc_q) * 33'(sb) + 33'(d);
         if (nxt >= (33'd1 << ACC_W)) begin
            big_q = 1'b1;
            acc_q = ACC_MAX;
         end else begin
            acc_q = nxt[ACC_W-1:0];
         end
      end
      if (!item.last_char) return;
      n_fields++;
      if (bad_q) begin
         push_error(1'b0);
      end else if (big_q) begin
         push_error(1'b1);
      end else begin
         to_base = eff_base(tgt_base_q);
         v = acc_q;
         cnt = 0;
         ovf = 1'b0;
         while (!ovf && (cnt == 0 || v != 0)) begin
            if (cnt == FIELD_WIDTH) begin
               ovf = 1'b1;
            end else begin
               digs[cnt] = DIG_W'(v % to_base);
               cnt++;
               v = v / to_base;
            end
         end
         if (ovf) begin
            push_error(1'b1);
         end else begin
            for (int i = cnt; i < FIELD_WIDTH; i++) push_char(CHAR_SPACE, 1'b0);
            for (int i = cnt - 1; i >= 0; i--) push_char(glyph(digs[i]), i == 0);
         end
      end
      acc_q = '0;
      big_q = 1'b0;
      bad_q = 1'b0;
   endfunction

   // result checker
   always @(posedge clock) begin : check_fields
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_out++;
         if (field_q.size() == 0) begin
            flag_error($sformatf("unexpected transaction: char %h last %b",
                                 rsp_data.out_char, rsp_data.out_last));
         end else begin
            want = field_q.pop_front();
            if (rsp_data.out_char !== want.out_char || rsp_data.out_last !== want.out_last)
               flag_error($sformatf("mismatch: expected char %h last %b, got char %h last %b",
                                    want.out_char, want.out_last,
                                    rsp_data.out_char, rsp_data.out_last));
         end
      end
   end

   // receiver pacing, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_out);
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] c, input bit l);
      req_type item;
      item.char_code = c;
      item.last_char = l;
      while ($urandom_range(99) < idle_in) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      fold_char(item);
      n_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // sender stops until every expected transaction is back
   task automatic drain_fields;
      req_valid <= 1'b0;
      while (field_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write then read back one base register
   task automatic program_base(input logic idx, input logic [BASE_W-1:0] b);
      logic [CSR_DATA_W-1:0] wdata;
      wdata = {$urandom()};
      wdata[BASE_W-1:0] = b;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == REG_SOURCE_BASE) src_base_q = b;
      else tgt_base_q = b;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(b))
         flag_error($sformatf("csr readback at %h: expected %h, got %h",
                              {idx, 2'b00}, CSR_DATA_W'(b), csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_bases(input logic [BASE_W-1:0] sb, input logic [BASE_W-1:0] tb_b);
      program_base(REG_SOURCE_BASE, sb);
      program_base(REG_TARGET_BASE, tb_b);
   endtask

   // mostly valid digits of the current base, some noise characters
   task automatic rand_number;
      int len;
      logic [CHAR_W-1:0] c;
      len = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0) c = CHAR_W'($urandom_range(255));
         else c = glyph(DIG_W'($urandom_range(eff_base(src_base_q) - 1)));
         send_char(c, i == len - 1);
      end
   endtask

   task automatic test_default_bases;
      send_text("0");
      send_text("1a");                // lower case is not a digit
      send_char(8'hFF, 1'b1);
      drain_fields();
   endtask

   task automatic test_saturation;
      set_bases(5'd16, 5'd16);
      send_text("FFFFFFFF");          // saturates the accumulator
      send_text("FFFFFFFFG");         // bad digit wins over saturation
      drain_fields();
      program_base(REG_TARGET_BASE, 5'd2);
      send_text("F0");                // eight binary digits do not fit
      drain_fields();
   endtask

   task automatic test_base_clamp;
      set_bases(5'd0, 5'd31);
      send_text("1");
      drain_fields();
      set_bases(5'd31, 5'd1);
      send_text("F");
      drain_fields();
      set_bases(5'd1, 5'd17);
      send_text("1");
      drain_fields();
   endtask

   task automatic test_backpressure;
      idle_in = 0;
      idle_out = 0;
      set_bases(5'd10, 5'd16);
      hold_seq++;
      for (int i = 0; i < 10; i++) begin
         for (int k = 0; k < 3; k++) send_char(glyph(DIG_W'($urandom_range(9))), k == 2);
      end
      drain_fields();
   endtask

   task automatic test_random(input int in_pct, input int out_pct);
      int start;
      int nums;
      idle_in = in_pct;
      idle_out = out_pct;
      start = n_items;
      nums = 0;
      while (n_items - start < RAND_ITEMS) begin
         if (nums % 6 == 0) begin
            drain_fields();
            if ($urandom_range(4) == 0)
               set_bases(BASE_W'($urandom_range(31)), BASE_W'($urandom_range(31)));
            else
               set_bases(BASE_W'($urandom_range(2, 16)), BASE_W'($urandom_range(2, 16)));
         end
         rand_number();
         nums++;
      end
      drain_fields();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_in = 19;
      idle_out = 45;
      test_default_bases();
      test_saturation();
      test_base_clamp();
      test_backpressure();
      test_random(19, 45);
      test_random(45, 19);
      test_random(0, 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d digit characters closing %0d numbers, checked %0d field characters",
               n_items, n_fields, n_out);
      $display("bases 0 to 31 on both registers, long receiver hold-off and random idling");
      if (n_errors == 0 && field_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("timeout with %0d transactions outstanding", field_q.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* sim.f */
src/rcff_pkg.sv
src/rcff_sequencer.sv
src/rcff_datapath.sv
src/radix_conversion_fixed_field.sv
src/rcff_checker.sv
dv/tb.sv
